>>> src/blr_pkg.sv
// Shared types and constants for the Bresenham line rasterizer.
// No dependencies; used by blr_front, blr_fifo, blr_back and the top level.
package blr_pkg;

  // Input item kind carried on in_tuser
  typedef enum logic {
    OP_START   = 1'b0,
    OP_ADVANCE = 1'b1
  } blr_op_t;

  // Depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

endpackage

>>> src/blr_fifo.sv
// Small register queue that decouples the setup front end from the pixel stepper.
// Depends on blr_pkg for the queue depth.
module blr_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] head_data
);

  localparam int DEPTH = blr_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign head_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> src/blr_front.sv
// Front end: classifies input items and does the line setup for start items
// (extents, major axis, endpoint order, minor direction). Uses blr_pkg.
module blr_front #(
  parameter int COORD_BITS = 11
) (
  input  blr_pkg::blr_op_t        op,
  input  logic [COORD_BITS-1:0]   start_x,
  input  logic [COORD_BITS-1:0]   start_y,
  input  logic [COORD_BITS-1:0]   end_x,
  input  logic [COORD_BITS-1:0]   end_y,
  // {minor_up, x_is_major, delta_minor, delta_major, stop_major, first_y, first_x, op}
  output logic [5*COORD_BITS+2:0] entry
);

  localparam int C = COORD_BITS;

  logic [C-1:0] dx, dy;
  logic         x_gt, y_gt, x_lt, y_lt;
  logic         x_major, swap, minor_up;
  logic [C-1:0] first_x, first_y, stop_major, d_major, d_minor;

  always_comb begin
    x_gt = start_x > end_x;
    x_lt = end_x > start_x;
    y_gt = start_y > end_y;
    y_lt = end_y > start_y;
    dx   = x_gt ? (start_x - end_x) : (end_x - start_x);
    dy   = y_gt ? (start_y - end_y) : (end_y - start_y);

    // ties go to x
    x_major = (dx >= dy);
    swap    = x_major ? x_gt : y_gt;

    first_x    = swap ? end_x : start_x;
    first_y    = swap ? end_y : start_y;
    stop_major = x_major ? (swap ? start_x : end_x) : (swap ? start_y : end_y);
    d_major    = x_major ? dx : dy;
    d_minor    = x_major ? dy : dx;
    // minor direction after the endpoints are ordered
    minor_up   = x_major ? (swap ? y_gt : y_lt) : (swap ? x_gt : x_lt);

    entry = {minor_up, x_major, d_minor, d_major, stop_major, first_y, first_x, op};
  end

endmodule

>>> src/blr_back.sv
// Back end: holds the active line and steps one pixel per advance entry
// while a line is active. Drives the registered result beat. Uses blr_pkg.
module blr_back #(
  parameter int COORD_BITS = 11
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_empty,
  input  logic [5*COORD_BITS+2:0] q_entry,
  output logic                    q_pop,
  output logic                    res_valid,
  input  logic                    res_ready,
  output logic [COORD_BITS-1:0]   res_x,
  output logic [COORD_BITS-1:0]   res_y,
  output logic                    res_pixel_valid,
  output logic                    res_last
);

  localparam int C = COORD_BITS;
  localparam int D = COORD_BITS + 2;

  blr_pkg::blr_op_t e_op;
  logic [C-1:0]     e_x, e_y, e_stop, e_dmaj, e_dmin;
  logic             e_xmaj, e_mup;

  // line state
  logic [C-1:0]        cur_x_r, cur_x_nxt;
  logic [C-1:0]        cur_y_r, cur_y_nxt;
  logic [C-1:0]        stop_r, stop_nxt;
  logic signed [D-1:0] dec_r, dec_nxt;
  logic signed [D-1:0] inc_pos_r, inc_pos_nxt;
  logic signed [D-1:0] inc_neg_r, inc_neg_nxt;
  logic                xmaj_r, xmaj_nxt;
  logic                mup_r, mup_nxt;
  logic                active_r, active_nxt;

  // result register
  logic         out_valid_r, out_valid_nxt;
  logic [C-1:0] out_x_r, out_x_nxt;
  logic [C-1:0] out_y_r, out_y_nxt;
  logic         out_pv_r, out_pv_nxt;
  logic         out_last_r, out_last_nxt;

  logic         step_minor;
  logic [C-1:0] major_inc, minor_step, major_cur, minor_cur;

  assign {e_mup, e_xmaj, e_dmin, e_dmaj, e_stop, e_y, e_x, e_op} = q_entry;

  assign q_pop = !q_empty && (!out_valid_r || res_ready);

  always_comb begin
    cur_x_nxt     = cur_x_r;
    cur_y_nxt     = cur_y_r;
    stop_nxt      = stop_r;
    dec_nxt       = dec_r;
    inc_pos_nxt   = inc_pos_r;
    inc_neg_nxt   = inc_neg_r;
    xmaj_nxt      = xmaj_r;
    mup_nxt       = mup_r;
    active_nxt    = active_r;
    out_valid_nxt = out_valid_r && !res_ready;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_pv_nxt    = out_pv_r;
    out_last_nxt  = out_last_r;

    step_minor = !dec_r[D-1];
    major_cur  = xmaj_r ? cur_x_r : cur_y_r;
    minor_cur  = xmaj_r ? cur_y_r : cur_x_r;
    major_inc  = major_cur + 1'b1;
    minor_step = !step_minor ? minor_cur : (mup_r ? minor_cur + 1'b1 : minor_cur - 1'b1);

    if (q_pop) begin
      out_valid_nxt = 1'b1;
      if (e_op == blr_pkg::OP_START) begin
        cur_x_nxt    = e_x;
        cur_y_nxt    = e_y;
        stop_nxt     = e_stop;
        xmaj_nxt     = e_xmaj;
        mup_nxt      = e_mup;
        inc_pos_nxt  = {1'b0, e_dmin, 1'b0};
        inc_neg_nxt  = {1'b0, e_dmin, 1'b0} - {1'b0, e_dmaj, 1'b0};
        dec_nxt      = {1'b0, e_dmin, 1'b0} - {2'b00, e_dmaj};
        active_nxt   = (e_dmaj != '0);
        out_x_nxt    = e_x;
        out_y_nxt    = e_y;
        out_pv_nxt   = 1'b1;
        out_last_nxt = (e_dmaj == '0);
      end else if (!active_r) begin
        out_x_nxt    = '0;
        out_y_nxt    = '0;
        out_pv_nxt   = 1'b0;
        out_last_nxt = 1'b0;
      end else begin
        dec_nxt    = dec_r + (step_minor ? inc_neg_r : inc_pos_r);
        cur_x_nxt  = xmaj_r ? major_inc : minor_step;
        cur_y_nxt  = xmaj_r ? minor_step : major_inc;
        active_nxt = (major_inc != stop_r);
        out_x_nxt    = cur_x_nxt;
        out_y_nxt    = cur_y_nxt;
        out_pv_nxt   = 1'b1;
        out_last_nxt = (major_inc == stop_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      xmaj_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      xmaj_r      <= xmaj_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_x_r    <= cur_x_nxt;
    cur_y_r    <= cur_y_nxt;
    stop_r     <= stop_nxt;
    dec_r      <= dec_nxt;
    inc_pos_r  <= inc_pos_nxt;
    inc_neg_r  <= inc_neg_nxt;
    mup_r      <= mup_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_pv_r   <= out_pv_nxt;
    out_last_r <= out_last_nxt;
  end

  assign res_valid       = out_valid_r;
  assign res_x           = out_x_r;
  assign res_y           = out_y_r;
  assign res_pixel_valid = out_pv_r;
  assign res_last        = out_last_r;

endmodule

>>> src/bresenham_line_rasterizer_unit.sv
// Bresenham line rasterizer, top level. An accepted input beat is set up into the queue,
// then stepped from the queue into the result register to form its result beat.
// Throughput: one beat per cycle, start or advance, unless out_tready holds back a result
// beat; the back end steps one pixel per cycle with one add and compare on the error term.
// Reset (rst_n low, synchronous): queue empty, no line active, no result pending.
// Depends on blr_pkg, blr_front, blr_fifo and blr_back.
module bresenham_line_rasterizer_unit #(
  parameter int COORD_BITS = 11
) (
  input  logic clk,
  input  logic rst_n,

  input  logic in_tvalid,
  output logic in_tready,
  // start_x, start_y, end_x, end_y from bit 0 up, zero padded to whole bytes
  input  logic [((4*COORD_BITS+7)/8)*8-1:0] in_tdata,
  // operation (0 start, 1 advance)
  input  logic in_tuser,

  output logic out_tvalid,
  input  logic out_tready,
  // pixel_x, pixel_y from bit 0 up, zero padded to whole bytes
  output logic [((2*COORD_BITS+7)/8)*8-1:0] out_tdata,
  // pixel_valid
  output logic out_tuser,
  // last_pixel
  output logic out_tlast
);

  localparam int C       = COORD_BITS;
  localparam int ENTRY_W = 5*COORD_BITS + 3;
  localparam int OUT_W   = ((2*COORD_BITS+7)/8)*8;

  logic [ENTRY_W-1:0] front_entry;
  logic [ENTRY_W-1:0] head_entry;
  logic               q_full, q_empty, q_pop, push;
  logic [C-1:0]       res_x, res_y;

  // accept whenever the queue has room; the back end drains it independently
  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;

  blr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .op      (blr_pkg::blr_op_t'(in_tuser)),
    .start_x (in_tdata[C-1:0]),
    .start_y (in_tdata[2*C-1:C]),
    .end_x   (in_tdata[3*C-1:2*C]),
    .end_y   (in_tdata[4*C-1:3*C]),
    .entry   (front_entry)
  );

  blr_fifo #(.WIDTH(ENTRY_W)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_entry),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head_data (head_entry)
  );

  // step the line and hold each result beat until the sink takes it
  blr_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .q_entry         (head_entry),
    .q_pop           (q_pop),
    .res_valid       (out_tvalid),
    .res_ready       (out_tready),
    .res_x           (res_x),
    .res_y           (res_y),
    .res_pixel_valid (out_tuser),
    .res_last        (out_tlast)
  );

  assign out_tdata = OUT_W'({res_y, res_x});

endmodule
